// ----- rtl/tsr_pkg.sv -----
// shared types, codes and constants of the tachometer speed regulator
// no dependencies
`timescale 1ns / 1ps

package tsr_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned RPM_W   = 16;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned DIV_W   = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

    localparam logic [CFG_IDX_W-1:0] CFG_RPM_SETPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_WINDOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DUTY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_DUTY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TMO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_DIR     = 3'd5;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [RPM_W-1:0]   RST_RPM_SETPOINT = 16'd1200;
    localparam logic [RPM_W-1:0]   RST_LOCK_WINDOW = 16'd15;
    localparam logic [PCT_W-1:0]   RST_HIGH_DUTY   = 7'd90;
    localparam logic [PCT_W-1:0]   RST_LOW_DUTY    = 7'd60;
    localparam logic [TIME_W-1:0]  RST_STALL_TMO   = 32'd3000000;
    localparam logic               RST_SPIN_DIR    = 1'b1;
    localparam logic [RPM_W-1:0]   RST_MEASURED_RPM = 16'd75;

    localparam logic [DIV_W-1:0]   US_PER_MS     = 32'd1000;
    localparam logic [DIV_W-1:0]   RPM_NUMERATOR = 32'd60000;
    localparam logic [DIV_W-1:0]   PCT_FULL      = 32'd100;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL    = 16'hFFFF;
    localparam logic [RPM_W-1:0]   RPM_SATURATED = 16'hFFFF;

    // x / 1000 as (x * MS_RECIP) >> MS_SHIFT, exact for any 32-bit x
    localparam int unsigned MS_SHIFT   = 38;
    localparam int unsigned MS_RECIP_W = 29;
    localparam int unsigned MS_PROD_W  = TIME_W + MS_RECIP_W;
    localparam logic [MS_RECIP_W-1:0] MS_RECIP =
        MS_RECIP_W'((64'd1 << MS_SHIFT) / 64'(US_PER_MS) + 64'd1);

    // pct * 65535 / 100 as (pct * LEVEL_RECIP) >> LEVEL_SHIFT, exact for 7-bit pct
    localparam int unsigned LEVEL_SHIFT   = 30;
    localparam int unsigned LEVEL_RECIP_W = 40;
    localparam int unsigned LEVEL_PROD_W  = PCT_W + LEVEL_RECIP_W;
    localparam logic [LEVEL_RECIP_W-1:0] LEVEL_RECIP =
        LEVEL_RECIP_W'(((64'd1 << LEVEL_SHIFT) / 64'(PCT_FULL) + 64'd1) * 64'(FULL_LEVEL));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MS,
        ST_RPM,
        ST_LEVEL,
        ST_WRITE
    } tsr_state_t;

    typedef struct packed {
        logic [RPM_W-1:0]  rpm_setpoint;
        logic [RPM_W-1:0]  lock_window;
        logic [PCT_W-1:0]  high_duty_pct;
        logic [PCT_W-1:0]  low_duty_pct;
        logic [TIME_W-1:0] stall_timeout_us;
        logic              spin_direction;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/tsr_div.sv -----
// shared 32-bit shift-subtract divider, one quotient bit per cycle
// depends on tsr_pkg
`timescale 1ns / 1ps

module tsr_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  tsr_pkg::div_req_t req,
    output tsr_pkg::div_rsp_t rsp
);

    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;
    logic [tsr_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [tsr_pkg::DIV_CNT_W-1:0]  cnt_next;
    logic [tsr_pkg::DIV_W-1:0]      rem_reg;
    logic [tsr_pkg::DIV_W-1:0]      rem_next;
    logic [tsr_pkg::DIV_W-1:0]      quo_reg;
    logic [tsr_pkg::DIV_W-1:0]      quo_next;
    logic [tsr_pkg::DIV_W-1:0]      dsr_reg;
    logic [tsr_pkg::DIV_W-1:0]      dsr_next;
    logic [tsr_pkg::DIV_W:0]        shifted;
    logic [tsr_pkg::DIV_W:0]        diff;
    logic                           fits;

    assign shifted = {rem_reg, quo_reg[tsr_pkg::DIV_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[tsr_pkg::DIV_W-1:0] : shifted[tsr_pkg::DIV_W-1:0];
            quo_next = {quo_reg[tsr_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tsr_pkg::DIV_CNT_W'(tsr_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- rtl/tsr_ctrl.sv -----
// sequencer, regulator state and output word register
// depends on tsr_pkg; drives the shared divider tsr_div
`timescale 1ns / 1ps

module tsr_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  tsr_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           operation,
    input  logic [tsr_pkg::TIME_W-1:0]     time_us,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tsr_pkg::LEVEL_W-1:0]    pwm_left_level,
    output logic [tsr_pkg::LEVEL_W-1:0]    pwm_right_level,
    output logic [tsr_pkg::RPM_W-1:0]      speed_rpm,
    output logic                           at_speed,
    output logic                           drive_on,
    output tsr_pkg::div_req_t              div_req,
    input  tsr_pkg::div_rsp_t              div_rsp
);

    tsr_pkg::tsr_state_t state_reg;
    tsr_pkg::tsr_state_t state_next;

    logic                          op_reg;
    logic                          op_next;
    logic [tsr_pkg::TIME_W-1:0]    time_reg;
    logic [tsr_pkg::TIME_W-1:0]    time_next;
    logic [tsr_pkg::TIME_W-1:0]    elapsed_reg;
    logic [tsr_pkg::TIME_W-1:0]    elapsed_next;
    logic [tsr_pkg::DIV_W-1:0]     q_reg;
    logic [tsr_pkg::DIV_W-1:0]     q_next;
    logic [tsr_pkg::RPM_W-1:0]     rpm_reg;
    logic [tsr_pkg::RPM_W-1:0]     rpm_next;
    logic [tsr_pkg::TIME_W-1:0]    last_edge_reg;
    logic [tsr_pkg::TIME_W-1:0]    last_edge_next;
    logic                          enabled_reg;
    logic                          enabled_next;
    logic                          at_target_reg;
    logic                          at_target_next;
    logic [tsr_pkg::LEVEL_W-1:0]   left_reg;
    logic [tsr_pkg::LEVEL_W-1:0]   left_next;
    logic [tsr_pkg::LEVEL_W-1:0]   right_reg;
    logic [tsr_pkg::LEVEL_W-1:0]   right_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [tsr_pkg::LEVEL_W-1:0]   out_left_reg;
    logic [tsr_pkg::LEVEL_W-1:0]   out_right_reg;
    logic [tsr_pkg::RPM_W-1:0]     out_rpm_reg;
    logic                          out_at_reg;
    logic                          out_on_reg;

    logic                          accept;
    logic                          write_out;
    logic [tsr_pkg::MS_PROD_W-1:0] ms_prod;
    logic [tsr_pkg::DIV_W-1:0]     ms;
    logic                          ms_zero;
    logic [tsr_pkg::PCT_W-1:0]     pct;
    logic [tsr_pkg::LEVEL_PROD_W-1:0] level_prod;
    logic [tsr_pkg::LEVEL_PROD_W-tsr_pkg::LEVEL_SHIFT-1:0] level_raw;
    logic [tsr_pkg::LEVEL_W-1:0]   level;
    logic [tsr_pkg::TIME_W-1:0]    elapsed_in;
    logic                          stale;
    logic signed [tsr_pkg::RPM_W+1:0] band_lo;
    logic [tsr_pkg::RPM_W:0]       band_hi;
    logic                          in_band;

    assign accept      = in_valid && in_ready;
    assign elapsed_in  = time_us - last_edge_reg;
    assign ms_prod     = tsr_pkg::MS_PROD_W'(elapsed_reg)
                         * tsr_pkg::MS_PROD_W'(tsr_pkg::MS_RECIP);
    assign ms          = tsr_pkg::DIV_W'(ms_prod[tsr_pkg::MS_PROD_W-1:tsr_pkg::MS_SHIFT]);
    assign ms_zero     = (ms == '0);
    assign stale       = elapsed_reg > cfg.stall_timeout_us;
    assign pct         = (rpm_reg < cfg.rpm_setpoint) ? cfg.high_duty_pct : cfg.low_duty_pct;
    assign level_prod  = tsr_pkg::LEVEL_PROD_W'(pct)
                         * tsr_pkg::LEVEL_PROD_W'(tsr_pkg::LEVEL_RECIP);
    assign level_raw   = level_prod[tsr_pkg::LEVEL_PROD_W-1:tsr_pkg::LEVEL_SHIFT];
    assign level       = (q_reg[tsr_pkg::DIV_W-1:tsr_pkg::LEVEL_W] != '0)
                         ? tsr_pkg::FULL_LEVEL : q_reg[tsr_pkg::LEVEL_W-1:0];
    assign band_lo     = $signed({2'b00, cfg.rpm_setpoint}) - $signed({2'b00, cfg.lock_window});
    assign band_hi     = {1'b0, cfg.rpm_setpoint} + {1'b0, cfg.lock_window};
    assign in_band     = ($signed({2'b00, rpm_reg}) > band_lo) && ({1'b0, rpm_reg} < band_hi);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (operation == tsr_pkg::OP_EDGE) ? tsr_pkg::ST_MS
                                                                 : tsr_pkg::ST_LEVEL;
                end
            end
            tsr_pkg::ST_MS:
            begin
                state_next = ms_zero ? tsr_pkg::ST_WRITE : tsr_pkg::ST_RPM;
            end
            tsr_pkg::ST_RPM:
            begin
                if (div_rsp.done)
                begin
                    state_next = tsr_pkg::ST_WRITE;
                end
            end
            tsr_pkg::ST_LEVEL:
            begin
                state_next = tsr_pkg::ST_WRITE;
            end
            tsr_pkg::ST_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = tsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsr_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready         = 1'b0;
        write_out        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = tsr_pkg::RPM_NUMERATOR;
        div_req.divisor  = ms;
        case (state_reg)
            tsr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            tsr_pkg::ST_MS:
            begin
                div_req.start = !ms_zero;
            end
            tsr_pkg::ST_WRITE:
            begin
                write_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        op_next        = op_reg;
        time_next      = time_reg;
        elapsed_next   = elapsed_reg;
        q_next         = q_reg;
        rpm_next       = rpm_reg;
        last_edge_next = last_edge_reg;
        enabled_next   = enabled_reg;
        at_target_next = at_target_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        if (accept)
        begin
            op_next      = operation;
            time_next    = time_us;
            elapsed_next = elapsed_in;
        end
        if (state_reg == tsr_pkg::ST_MS && ms_zero)
        begin
            q_next = tsr_pkg::DIV_W'(tsr_pkg::RPM_SATURATED);
        end
        if (state_reg == tsr_pkg::ST_RPM && div_rsp.done)
        begin
            q_next = div_rsp.quotient;
        end
        if (state_reg == tsr_pkg::ST_LEVEL)
        begin
            q_next = tsr_pkg::DIV_W'(level_raw);
        end
        if (write_out)
        begin
            if (op_reg == tsr_pkg::OP_EDGE)
            begin
                rpm_next       = q_reg[tsr_pkg::RPM_W-1:0];
                last_edge_next = time_reg;
            end
            else
            begin
                if (enabled_reg)
                begin
                    left_next      = cfg.spin_direction ? '0 : level;
                    right_next     = cfg.spin_direction ? level : '0;
                    at_target_next = in_band;
                end
                else
                begin
                    left_next  = '0;
                    right_next = '0;
                end
                if (stale)
                begin
                    enabled_next   = 1'b0;
                    at_target_next = 1'b0;
                end
                else
                begin
                    enabled_next = 1'b1;
                end
            end
        end
        out_valid_next = write_out ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsr_pkg::ST_IDLE;
            rpm_reg       <= tsr_pkg::RST_MEASURED_RPM;
            last_edge_reg <= '0;
            enabled_reg   <= 1'b0;
            at_target_reg <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rpm_reg       <= rpm_next;
            last_edge_reg <= last_edge_next;
            enabled_reg   <= enabled_next;
            at_target_reg <= at_target_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        time_reg    <= time_next;
        elapsed_reg <= elapsed_next;
        q_reg       <= q_next;
        if (write_out)
        begin
            out_left_reg  <= left_next;
            out_right_reg <= right_next;
            out_rpm_reg   <= rpm_next;
            out_at_reg    <= at_target_next;
            out_on_reg    <= enabled_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pwm_left_level  = out_left_reg;
    assign pwm_right_level = out_right_reg;
    assign speed_rpm       = out_rpm_reg;
    assign at_speed        = out_at_reg;
    assign drive_on        = out_on_reg;

    a_start_placement: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (state_reg == tsr_pkg::ST_MS))
        else $error("divider started outside millisecond step");

    a_lock_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
        at_target_reg |-> enabled_reg)
        else $error("at-target flag set while drive is off");

    a_one_side_driven: assert property (@(posedge clk) disable iff (!rst_n)
        !(left_reg != '0 && right_reg != '0))
        else $error("both pwm levels nonzero");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != tsr_pkg::ST_IDLE)
        else $error("accepted word did not start the sequencer");

endmodule

// ----- rtl/tach_speed_regulator_core.sv -----
// top level of the tachometer speed regulator: configuration registers and instances
// depends on tsr_pkg, tsr_div, tsr_ctrl
`timescale 1ns / 1ps

// Bang-bang motor speed regulator. Each input word is a tachometer edge or a control
// tick with a 32-bit microsecond timestamp; each word yields one output word with the
// state after the update. One word is handled at a time and in_ready is low while it is
// worked on. Whole milliseconds and the duty level come from constant reciprocal
// multiplies; 60000/ms goes through a shared shift-subtract divider that produces one
// quotient bit per cycle. A tick goes through the level and write steps; an edge goes
// through the millisecond step, the divider and the write step, or skips the divider with
// a saturated speed when the edges are less than one millisecond apart. The output word
// is registered, so a word not yet taken holds only the write step of the next one.
// Configuration is written through cfg_write_en/cfg_index/cfg_data and takes effect at
// once; write it only while idle.

module tach_speed_regulator_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [tsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic [tsr_pkg::TIME_W-1:0]        time_us,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tsr_pkg::LEVEL_W-1:0]       pwm_left_level,
    output logic [tsr_pkg::LEVEL_W-1:0]       pwm_right_level,
    output logic [tsr_pkg::RPM_W-1:0]         speed_rpm,
    output logic                              at_speed,
    output logic                              drive_on
);

    tsr_pkg::cfg_t     cfg_reg;
    tsr_pkg::cfg_t     cfg_next;
    tsr_pkg::div_req_t div_req;
    tsr_pkg::div_rsp_t div_rsp;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                tsr_pkg::CFG_RPM_SETPOINT:
                    cfg_next.rpm_setpoint = cfg_data[tsr_pkg::RPM_W-1:0];
                tsr_pkg::CFG_LOCK_WINDOW:
                    cfg_next.lock_window = cfg_data[tsr_pkg::RPM_W-1:0];
                tsr_pkg::CFG_HIGH_DUTY:
                    cfg_next.high_duty_pct = cfg_data[tsr_pkg::PCT_W-1:0];
                tsr_pkg::CFG_LOW_DUTY:
                    cfg_next.low_duty_pct = cfg_data[tsr_pkg::PCT_W-1:0];
                tsr_pkg::CFG_STALL_TMO:
                    cfg_next.stall_timeout_us = cfg_data[tsr_pkg::TIME_W-1:0];
                tsr_pkg::CFG_SPIN_DIR:
                    cfg_next.spin_direction = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rpm_setpoint     <= tsr_pkg::RST_RPM_SETPOINT;
            cfg_reg.lock_window      <= tsr_pkg::RST_LOCK_WINDOW;
            cfg_reg.high_duty_pct    <= tsr_pkg::RST_HIGH_DUTY;
            cfg_reg.low_duty_pct     <= tsr_pkg::RST_LOW_DUTY;
            cfg_reg.stall_timeout_us <= tsr_pkg::RST_STALL_TMO;
            cfg_reg.spin_direction   <= tsr_pkg::RST_SPIN_DIR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tsr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tsr_ctrl u_ctrl
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .time_us         (time_us),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pwm_left_level  (pwm_left_level),
        .pwm_right_level (pwm_right_level),
        .speed_rpm       (speed_rpm),
        .at_speed        (at_speed),
        .drive_on        (drive_on),
        .div_req         (div_req),
        .div_rsp         (div_rsp)
    );

endmodule
